/* sv/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types, widths and register indexes for the byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Width of the phase tick counter.
  localparam int COUNT_BITS = 8;
  localparam int CMP_W      = (COUNT_BITS > 8) ? COUNT_BITS : 8;

  typedef logic [COUNT_BITS-1:0] tick_cnt_t;

  localparam tick_cnt_t TICK_ZERO = '0;
  localparam tick_cnt_t TICK_ONE  = tick_cnt_t'(1);
  localparam tick_cnt_t TICK_MAX  = '1;

  // Opcodes.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HIGH_PHASE = 2'd0;
  localparam logic [1:0] CFG_LOW_PHASE  = 2'd1;

  // Input beat as it arrives on the port.
  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] opcode;
    logic [7:0] write_data;
    logic       send_nack;
    logic       sda_in;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_bit;
  } res_item_t;

  // Classified tick handed from the front to the engine.
  typedef struct packed {
    logic       go_bus;    // start or stop command
    logic       go_start;  // start/restart (with go_bus)
    logic       go_byte;   // write or read command
    logic       go_write;  // write (with go_byte)
    logic [7:0] wdata;
    logic       nack;
    logic       sda;
  } tick_t;

  // Saturate a phase length into the counter range; zero acts as one.
  function automatic tick_cnt_t clamp_len(input logic [7:0] v);
    logic [CMP_W-1:0] ve;
    logic [CMP_W-1:0] m;
    ve = CMP_W'(v);
    m  = CMP_W'(TICK_MAX);
    if (ve == '0) begin
      ve = CMP_W'(1);
    end
    if (ve > m) begin
      ve = m;
    end
    return ve[COUNT_BITS-1:0];
  endfunction

endpackage

/* sv/i2cm_front.sv */
// ----------------------------------------------------------------------------
// I2C master front end
// Accepts input beats, classifies the command and queues them for the engine.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  i2cm_pkg::in_item_t item,
  output logic               q_valid,
  output i2cm_pkg::tick_t    q_item,
  input  logic               q_take
);

  i2cm_pkg::tick_t entry [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_push;
  logic            do_pop;
  i2cm_pkg::tick_t cls;

  always_comb begin
    cls.go_bus   = item.cmd_valid &&
                   (item.opcode == i2cm_pkg::OP_START || item.opcode == i2cm_pkg::OP_STOP);
    cls.go_start = item.opcode == i2cm_pkg::OP_START;
    cls.go_byte  = item.cmd_valid &&
                   (item.opcode == i2cm_pkg::OP_WRITE || item.opcode == i2cm_pkg::OP_READ);
    cls.go_write = item.opcode == i2cm_pkg::OP_WRITE;
    cls.wdata    = item.write_data;
    cls.nack     = item.send_nack;
    cls.sda      = item.sda_in;
  end

  assign full    = count == 2'd2;
  assign q_valid = count != 2'd0;
  assign q_item  = entry[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

`ifndef ASSERT_OFF
  a_front_count: assert property (@(posedge clk) disable iff (rst)
    (count <= 2'd2) && (q_valid == (count != 2'd0)))
    else $error("front queue count out of range");
`endif

endmodule

/* sv/i2cm_engine.sv */
// ----------------------------------------------------------------------------
// I2C master bus engine
// Runs the bus phase sequencer one tick per beat and queues the results.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          hi_ticks,
  input  logic [7:0]          lo_ticks,
  input  logic                q_valid,
  input  i2cm_pkg::tick_t     q_item,
  output logic                q_take,
  output logic                empty,
  input  logic                pop,
  output i2cm_pkg::res_item_t result
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_STOP  = 4'd1;
  localparam logic [3:0] PH_RSTOP = 4'd2;
  localparam logic [3:0] PH_START = 4'd3;
  localparam logic [3:0] PH_WLOW  = 4'd4;
  localparam logic [3:0] PH_WHIGH = 4'd5;
  localparam logic [3:0] PH_RLOW  = 4'd6;
  localparam logic [3:0] PH_RHIGH = 4'd7;
  localparam logic [3:0] PH_TAIL  = 4'd8;

  logic [3:0]          phase,       phase_next;
  logic [3:0]          bit_count,   bit_count_next;
  logic [7:0]          shift_reg,   shift_reg_next;
  i2cm_pkg::tick_cnt_t tick_count,  tick_count_next;
  logic                scl_low_reg, scl_low_reg_next;
  logic                sda_low_reg, sda_low_reg_next;
  logic                ack_reg,     ack_reg_next;
  logic                nack_reg,    nack_reg_next;
  logic [7:0]          rx_byte,     rx_byte_next;
  logic                done;
  i2cm_pkg::tick_cnt_t hi_len;
  i2cm_pkg::tick_cnt_t lo_len;
  i2cm_pkg::tick_cnt_t tick_bump;
  i2cm_pkg::res_item_t res_new;

  i2cm_pkg::res_item_t rq [2];
  logic                rq_wr;
  logic                rq_rd;
  logic [1:0]          rq_count;
  logic                do_pop;

  assign hi_len    = i2cm_pkg::clamp_len(hi_ticks);
  assign lo_len    = i2cm_pkg::clamp_len(lo_ticks);
  assign tick_bump = (tick_count == i2cm_pkg::TICK_MAX) ? tick_count
                                                        : tick_count + i2cm_pkg::TICK_ONE;

  // Step whenever a tick waits and the result queue has a free slot.
  assign q_take = q_valid && (rq_count != 2'd2);
  assign do_pop = pop && !empty;

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    tick_count_next  = tick_count;
    scl_low_reg_next = scl_low_reg;
    sda_low_reg_next = sda_low_reg;
    ack_reg_next     = ack_reg;
    nack_reg_next    = nack_reg;
    rx_byte_next     = rx_byte;
    done             = 1'b0;
    unique case (phase) inside
      PH_IDLE: begin
        if (q_item.go_bus) begin
          scl_low_reg_next = 1'b0;
          tick_count_next  = i2cm_pkg::TICK_ONE;
          phase_next       = q_item.go_start ? PH_RSTOP : PH_STOP;
        end else if (q_item.go_byte) begin
          scl_low_reg_next = 1'b1;
          tick_count_next  = i2cm_pkg::TICK_ZERO;
          bit_count_next   = 4'd0;
          if (q_item.go_write) begin
            shift_reg_next = q_item.wdata;
            phase_next     = PH_WLOW;
          end else begin
            shift_reg_next = 8'd0;
            nack_reg_next  = q_item.nack;
            phase_next     = PH_RLOW;
          end
        end
      end
      PH_STOP, PH_RSTOP: begin
        if (tick_count >= hi_len) begin
          sda_low_reg_next = 1'b0;
          if (phase == PH_STOP) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else begin
            phase_next      = PH_START;
            tick_count_next = i2cm_pkg::TICK_ZERO;
          end
        end else begin
          tick_count_next = tick_bump;
        end
      end
      PH_START: begin
        if (tick_count >= hi_len) begin
          scl_low_reg_next = 1'b1;
          phase_next       = PH_IDLE;
          done             = 1'b1;
        end else begin
          tick_count_next  = tick_bump;
          sda_low_reg_next = 1'b1;
        end
      end
      PH_WLOW, PH_RLOW: begin
        if (tick_count >= lo_len) begin
          scl_low_reg_next = 1'b0;
          tick_count_next  = i2cm_pkg::TICK_ONE;
          phase_next       = (phase == PH_WLOW) ? PH_WHIGH : PH_RHIGH;
        end else begin
          tick_count_next = tick_bump;
          if (phase == PH_WLOW) begin
            sda_low_reg_next = bit_count[3] ? 1'b0 : !shift_reg[7];
          end else begin
            sda_low_reg_next = bit_count[3] ? !nack_reg : 1'b0;
          end
        end
      end
      PH_WHIGH, PH_RHIGH: begin
        if (tick_count >= hi_len) begin
          scl_low_reg_next = 1'b1;
          tick_count_next  = i2cm_pkg::TICK_ZERO;
          if (bit_count[3]) begin
            if (phase == PH_WHIGH) begin
              ack_reg_next = q_item.sda;
            end else begin
              rx_byte_next = shift_reg;
            end
            phase_next = PH_TAIL;
          end else begin
            if (phase == PH_WHIGH) begin
              shift_reg_next = {shift_reg[6:0], 1'b0};
              phase_next     = PH_WLOW;
            end else begin
              shift_reg_next = {shift_reg[6:0], q_item.sda};
              phase_next     = PH_RLOW;
            end
            bit_count_next = bit_count + 4'd1;
          end
        end else begin
          tick_count_next = tick_bump;
        end
      end
      PH_TAIL: begin
        sda_low_reg_next = 1'b1;
        phase_next       = PH_IDLE;
        done             = 1'b1;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    res_new.scl_drive_low = scl_low_reg_next;
    res_new.sda_drive_low = sda_low_reg_next;
    res_new.busy_res      = phase_next != PH_IDLE;
    res_new.done_res      = done;
    res_new.read_data     = rx_byte_next;
    res_new.ack_bit       = ack_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= 4'd0;
      shift_reg   <= 8'd0;
      tick_count  <= i2cm_pkg::TICK_ZERO;
      scl_low_reg <= 1'b0;
      sda_low_reg <= 1'b0;
      ack_reg     <= 1'b1;
      nack_reg    <= 1'b0;
      rx_byte     <= 8'd0;
    end else if (q_take) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      tick_count  <= tick_count_next;
      scl_low_reg <= scl_low_reg_next;
      sda_low_reg <= sda_low_reg_next;
      ack_reg     <= ack_reg_next;
      nack_reg    <= nack_reg_next;
      rx_byte     <= rx_byte_next;
    end
  end

  // Result queue: one beat per step.
  assign empty  = rq_count == 2'd0;
  assign result = rq[rq_rd];

  always_ff @(posedge clk) begin
    if (q_take) begin
      rq[rq_wr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= 1'b0;
      rq_rd    <= 1'b0;
      rq_count <= 2'd0;
    end else begin
      if (q_take) begin
        rq_wr <= !rq_wr;
      end
      if (do_pop) begin
        rq_rd <= !rq_rd;
      end
      rq_count <= rq_count + 2'(q_take) - 2'(do_pop);
    end
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    q_take && done |=> phase == PH_IDLE)
    else $error("completed command left the engine busy");
  a_tail_idle: assert property (@(posedge clk) disable iff (rst)
    q_take && phase == PH_TAIL |=> phase == PH_IDLE && sda_low_reg)
    else $error("tail phase did not return to idle with SDA low");
  a_bit_count: assert property (@(posedge clk) disable iff (rst)
    bit_count <= 4'd8 && rq_count <= 2'd2)
    else $error("bit count or result queue out of range");
`endif

endmodule

/* sv/i2c_master_byte_engine_top.sv */
// Two-deep queues sit on each side. A tick beat is written into the front queue and stepped by
// the engine once the result queue has room; its result is queued there, ready to be popped.
// Throughput: one beat per cycle while the result queue has room; engine steps once per cycle.
// Reset (rst, synchronous): bus released, engine idle, queues empty, read byte 0, ack 1,
// high phase 3 ticks and low phase 1 tick.
// ----------------------------------------------------------------------------
// I2C master byte engine, top level
// Open-drain I2C master: each input beat is one timing tick, each tick yields
// one result beat with the line drives and status after that tick.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_top (
  input  logic                clk,
  input  logic                rst,
  // tick input queue
  input  logic                push,
  output logic                full,
  input  i2cm_pkg::in_item_t  item,
  // result queue
  output logic                empty,
  input  logic                pop,
  output i2cm_pkg::res_item_t result,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  logic            q_valid;
  logic            q_take;
  i2cm_pkg::tick_t q_item;
  logic [7:0]      high_phase_ticks;
  logic [7:0]      low_phase_ticks;

  // Take configuration writes at any time; index values beyond the list drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_phase_ticks <= 8'd3;
      low_phase_ticks  <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == i2cm_pkg::CFG_HIGH_PHASE) begin
        high_phase_ticks <= cfg_data;
      end else if (cfg_index == i2cm_pkg::CFG_LOW_PHASE) begin
        low_phase_ticks <= cfg_data;
      end
    end
  end

  // Front: classify each tick and hold it until the engine takes it.
  i2cm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take)
  );

  // Back: advance the bus sequencer one tick per beat and queue the result.
  i2cm_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .hi_ticks (high_phase_ticks),
    .lo_ticks (low_phase_ticks),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
